@@ src/vcd_pkg.sv @@
package vcd_pkg;

  // Command codes (tuser of the input stream)
  localparam logic [1:0] CMD_AC    = 2'd0;
  localparam logic [1:0] CMD_FIRST = 2'd1;
  localparam logic [1:0] CMD_EOB   = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // Status codes (tuser of the output stream)
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MORE    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  // Leading window bits that any decision can look at
  localparam int unsigned USE_BITS = 28;
  localparam int unsigned PFX_BITS = 16;
  localparam int unsigned VLC_CODES = 111;

  // Escape prefix 000001, the escape header and form lengths, and the MPEG-1 extension markers
  localparam logic [5:0] ESC_CODE  = 6'b000001;
  localparam logic [5:0] ESC_HDR   = 6'd12;
  localparam logic [5:0] ESC1_SHORT = 6'd20;
  localparam logic [5:0] ESC1_LONG  = 6'd28;
  localparam logic [5:0] ESC2_LEN   = 6'd24;
  localparam logic [7:0] ESC1_EXT_POS = 8'd0;
  localparam logic [7:0] ESC1_EXT_NEG = 8'd128;

  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [4:0] len;
    logic [5:0] code;
    logic [4:0] run;
    logic [5:0] level;
  } vlc_entry_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] len;
    logic [4:0] run;
    logic [5:0] level;
  } vlc_hit_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [USE_BITS-1:0] win;
    logic [5:0]          avail;
    logic                mpeg1;
  } align_t;

  typedef struct packed {
    align_t   base;
    vlc_hit_t code;
    logic     esc;
  } match_t;

  // Result beat, run in the lowest bits
  typedef struct packed {
    logic              eob;
    logic [4:0]        consumed;
    logic signed [11:0] level;
    logic [5:0]        run;
  } result_t;

  // Table zero: length, code, run, level magnitude
  localparam vlc_entry_t VLC_TABLE [VLC_CODES] = '{
    '{5'd2, 6'h03, 5'd0, 6'd1},
    '{5'd3, 6'h03, 5'd1, 6'd1},
    '{5'd4, 6'h04, 5'd0, 6'd2}, '{5'd4, 6'h05, 5'd2, 6'd1},
    '{5'd5, 6'h05, 5'd0, 6'd3}, '{5'd5, 6'h07, 5'd3, 6'd1}, '{5'd5, 6'h06, 5'd4, 6'd1},
    '{5'd6, 6'h06, 5'd1, 6'd2}, '{5'd6, 6'h07, 5'd5, 6'd1},
    '{5'd6, 6'h05, 5'd6, 6'd1}, '{5'd6, 6'h04, 5'd7, 6'd1},
    '{5'd7, 6'h06, 5'd0, 6'd4}, '{5'd7, 6'h04, 5'd2, 6'd2},
    '{5'd7, 6'h07, 5'd8, 6'd1}, '{5'd7, 6'h05, 5'd9, 6'd1},
    '{5'd8, 6'h26, 5'd0, 6'd5}, '{5'd8, 6'h21, 5'd0, 6'd6},
    '{5'd8, 6'h25, 5'd1, 6'd3}, '{5'd8, 6'h24, 5'd3, 6'd2},
    '{5'd8, 6'h27, 5'd10, 6'd1}, '{5'd8, 6'h23, 5'd11, 6'd1},
    '{5'd8, 6'h22, 5'd12, 6'd1}, '{5'd8, 6'h20, 5'd13, 6'd1},
    '{5'd10, 6'h0A, 5'd0, 6'd7}, '{5'd10, 6'h0C, 5'd1, 6'd4},
    '{5'd10, 6'h0B, 5'd2, 6'd3}, '{5'd10, 6'h0F, 5'd4, 6'd2},
    '{5'd10, 6'h09, 5'd5, 6'd2}, '{5'd10, 6'h0E, 5'd14, 6'd1},
    '{5'd10, 6'h0D, 5'd15, 6'd1}, '{5'd10, 6'h08, 5'd16, 6'd1},
    '{5'd12, 6'h1D, 5'd0, 6'd8}, '{5'd12, 6'h18, 5'd0, 6'd9},
    '{5'd12, 6'h13, 5'd0, 6'd10}, '{5'd12, 6'h10, 5'd0, 6'd11},
    '{5'd12, 6'h1B, 5'd1, 6'd5}, '{5'd12, 6'h14, 5'd2, 6'd4},
    '{5'd12, 6'h1C, 5'd3, 6'd3}, '{5'd12, 6'h12, 5'd4, 6'd3},
    '{5'd12, 6'h1E, 5'd6, 6'd2}, '{5'd12, 6'h15, 5'd7, 6'd2},
    '{5'd12, 6'h11, 5'd8, 6'd2}, '{5'd12, 6'h1F, 5'd17, 6'd1},
    '{5'd12, 6'h1A, 5'd18, 6'd1}, '{5'd12, 6'h19, 5'd19, 6'd1},
    '{5'd12, 6'h17, 5'd20, 6'd1}, '{5'd12, 6'h16, 5'd21, 6'd1},
    '{5'd13, 6'h1A, 5'd0, 6'd12}, '{5'd13, 6'h19, 5'd0, 6'd13},
    '{5'd13, 6'h18, 5'd0, 6'd14}, '{5'd13, 6'h17, 5'd0, 6'd15},
    '{5'd13, 6'h16, 5'd1, 6'd6}, '{5'd13, 6'h15, 5'd1, 6'd7},
    '{5'd13, 6'h14, 5'd2, 6'd5}, '{5'd13, 6'h13, 5'd3, 6'd4},
    '{5'd13, 6'h12, 5'd5, 6'd3}, '{5'd13, 6'h11, 5'd9, 6'd2},
    '{5'd13, 6'h10, 5'd10, 6'd2}, '{5'd13, 6'h1F, 5'd22, 6'd1},
    '{5'd13, 6'h1E, 5'd23, 6'd1}, '{5'd13, 6'h1D, 5'd24, 6'd1},
    '{5'd13, 6'h1C, 5'd25, 6'd1}, '{5'd13, 6'h1B, 5'd26, 6'd1},
    '{5'd14, 6'h1F, 5'd0, 6'd16}, '{5'd14, 6'h1E, 5'd0, 6'd17},
    '{5'd14, 6'h1D, 5'd0, 6'd18}, '{5'd14, 6'h1C, 5'd0, 6'd19},
    '{5'd14, 6'h1B, 5'd0, 6'd20}, '{5'd14, 6'h1A, 5'd0, 6'd21},
    '{5'd14, 6'h19, 5'd0, 6'd22}, '{5'd14, 6'h18, 5'd0, 6'd23},
    '{5'd14, 6'h17, 5'd0, 6'd24}, '{5'd14, 6'h16, 5'd0, 6'd25},
    '{5'd14, 6'h15, 5'd0, 6'd26}, '{5'd14, 6'h14, 5'd0, 6'd27},
    '{5'd14, 6'h13, 5'd0, 6'd28}, '{5'd14, 6'h12, 5'd0, 6'd29},
    '{5'd14, 6'h11, 5'd0, 6'd30}, '{5'd14, 6'h10, 5'd0, 6'd31},
    '{5'd15, 6'h18, 5'd0, 6'd32}, '{5'd15, 6'h17, 5'd0, 6'd33},
    '{5'd15, 6'h16, 5'd0, 6'd34}, '{5'd15, 6'h15, 5'd0, 6'd35},
    '{5'd15, 6'h14, 5'd0, 6'd36}, '{5'd15, 6'h13, 5'd0, 6'd37},
    '{5'd15, 6'h12, 5'd0, 6'd38}, '{5'd15, 6'h11, 5'd0, 6'd39},
    '{5'd15, 6'h10, 5'd0, 6'd40}, '{5'd15, 6'h1F, 5'd1, 6'd8},
    '{5'd15, 6'h1E, 5'd1, 6'd9}, '{5'd15, 6'h1D, 5'd1, 6'd10},
    '{5'd15, 6'h1C, 5'd1, 6'd11}, '{5'd15, 6'h1B, 5'd1, 6'd12},
    '{5'd15, 6'h1A, 5'd1, 6'd13}, '{5'd15, 6'h19, 5'd1, 6'd14},
    '{5'd16, 6'h13, 5'd1, 6'd15}, '{5'd16, 6'h12, 5'd1, 6'd16},
    '{5'd16, 6'h11, 5'd1, 6'd17}, '{5'd16, 6'h10, 5'd1, 6'd18},
    '{5'd16, 6'h14, 5'd6, 6'd3}, '{5'd16, 6'h1A, 5'd11, 6'd2},
    '{5'd16, 6'h19, 5'd12, 6'd2}, '{5'd16, 6'h18, 5'd13, 6'd2},
    '{5'd16, 6'h17, 5'd14, 6'd2}, '{5'd16, 6'h16, 5'd15, 6'd2},
    '{5'd16, 6'h15, 5'd16, 6'd2}, '{5'd16, 6'h1F, 5'd27, 6'd1},
    '{5'd16, 6'h1E, 5'd28, 6'd1}, '{5'd16, 6'h1D, 5'd29, 6'd1},
    '{5'd16, 6'h1C, 5'd30, 6'd1}, '{5'd16, 6'h1B, 5'd31, 6'd1}
  };

  // Match the 16-bit prefix against every table code in parallel; codes are
  // prefix-free, so at most one entry hits.
  function automatic vlc_hit_t vlc_lookup(input logic [PFX_BITS-1:0] pfx);
    vlc_hit_t r;
    r = '0;
    for (int i = VLC_CODES - 1; i >= 0; i--) begin
      if ((pfx >> (5'd16 - VLC_TABLE[i].len)) == 16'(VLC_TABLE[i].code)) begin
        r.hit   = 1'b1;
        r.len   = VLC_TABLE[i].len;
        r.run   = VLC_TABLE[i].run;
        r.level = VLC_TABLE[i].level;
      end
    end
    return r;
  endfunction

endpackage

@@ src/dct_coefficient_vlc_decoder.sv @@
// MPEG DCT coefficient decoder for table zero. Each input beat carries a
// command in tuser (AC coefficient, first coefficient, end-of-block test) and
// in tdata a bit window, first stream bit in the top position, with the count
// of leading valid bits; bits past that count are ignored and a count above
// the window width is clamped. Each input beat yields exactly one output
// beat: the status in tuser (decoded, need more bits, no matching code) and
// in tdata the run, the signed 12-bit level, the number of bits to advance
// (sign and escape fields included) and the end-of-block flag; every field
// is zero unless the status is decoded. The escape level format follows the
// one-bit mode register written through cfg_we_i / cfg_wdata_i (1 selects
// the MPEG-1 8/16-bit form, 0 the MPEG-2 12-bit form; reset 0); write it only
// while no beat is in flight. Throughput is one beat per clock while the output
// is not stalled. The three register stages are window clamp and mask,
// parallel code-table match on the 16-bit prefix, and sign/escape resolve,
// whose register drives the output port. Every stage has its own valid bit
// and takes a new beat whenever it is empty or its successor takes its beat,
// so a stalled output keeps accepting input until all three stages are full.
module dct_coefficient_vlc_decoder #(
  parameter int unsigned WINDOW_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: mode register
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: bit_window[WINDOW_BITS-1:0], bits_valid[5:0], zero fill
  input  logic [((WINDOW_BITS+6+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [1:0]                    s_axis_tuser_i,
  // Output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: run_length[5:0], coeff_level[11:0], bits_consumed[4:0], is_eob
  output logic [vcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]                    m_axis_tuser_o
);

  logic mpeg1_q;

  logic            align_valid, align_ready;
  vcd_pkg::align_t align_data;
  logic            match_valid, match_ready;
  vcd_pkg::match_t match_data;
  vcd_pkg::result_t result;

  // Hold the escape format until the next write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpeg1_q <= 1'b0;
    end else if (cfg_we_i) begin
      mpeg1_q <= cfg_wdata_i;
    end
  end

  // Stage 1: clamp the valid count and clear the invalid window bits
  vcd_align #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_align (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid_i),
    .ready_o     (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .bit_window_i(s_axis_tdata_i[WINDOW_BITS-1:0]),
    .bits_valid_i(s_axis_tdata_i[WINDOW_BITS+5:WINDOW_BITS]),
    .mpeg1_i     (mpeg1_q),
    .valid_o     (align_valid),
    .ready_i     (align_ready),
    .data_o      (align_data)
  );

  // Stage 2: match the prefix against the code table, detect escape
  vcd_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(align_valid),
    .ready_o(align_ready),
    .data_i (align_data),
    .valid_o(match_valid),
    .ready_i(match_ready),
    .data_o (match_data)
  );

  // Stage 3: apply sign, escape fields and bit-count checks
  vcd_resolve u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (match_valid),
    .ready_o (match_ready),
    .data_i  (match_data),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .status_o(m_axis_tuser_o),
    .result_o(result)
  );

  assign m_axis_tdata_o = result;

  // Fields are zero on any beat that is not decoded
  a_zero_unless_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != vcd_pkg::ST_OK) |-> (result == '0))
    else $error("non-decoded beat carries field data");

  // An end-of-block hit never advances the stream
  a_eob_no_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && result.eob) |->
      (result.consumed == 5'd0 && result.run == 6'd0 && result.level == 12'sd0))
    else $error("end-of-block beat advances the stream");

  // A decoded coefficient takes at least a two-bit code
  a_min_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && result.consumed != 5'd0) |-> (result.consumed >= 5'd2))
    else $error("coefficient shorter than two bits");

  // Input stalls only when every stage is full and the output is held
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i
                          && align_valid && match_valid))
    else $error("input stalled with an empty stage");

endmodule

@@ src/vcd_align.sv @@
module vcd_align #(
  parameter int unsigned WINDOW_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [1:0]             cmd_i,
  input  logic [WINDOW_BITS-1:0] bit_window_i,
  input  logic [5:0]             bits_valid_i,
  input  logic                   mpeg1_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output vcd_pkg::align_t        data_o
);

  localparam int unsigned AVAIL_MAX = (WINDOW_BITS > 63) ? 63 : WINDOW_BITS;

  logic            valid_q;
  vcd_pkg::align_t data_d, data_q;
  logic [5:0]      avail;

  // Clamp the valid count, then clear every leading bit past it
  always_comb begin
    avail = (bits_valid_i > 6'(AVAIL_MAX)) ? 6'(AVAIL_MAX) : bits_valid_i;
    data_d.cmd   = cmd_i;
    data_d.avail = avail;
    data_d.mpeg1 = mpeg1_i;
    for (int p = 0; p < vcd_pkg::USE_BITS; p++) begin
      data_d.win[vcd_pkg::USE_BITS-1-p] =
        bit_window_i[WINDOW_BITS-1-p] & (6'(p) < avail);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/vcd_match.sv @@
module vcd_match (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  vcd_pkg::align_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output vcd_pkg::match_t data_o
);

  logic            valid_q;
  vcd_pkg::match_t data_d, data_q;

  always_comb begin
    data_d.base = data_i;
    data_d.code = vcd_pkg::vlc_lookup(
      data_i.win[vcd_pkg::USE_BITS-1 -: vcd_pkg::PFX_BITS]);
    data_d.esc  = (data_i.win[vcd_pkg::USE_BITS-1 -: 6] == vcd_pkg::ESC_CODE);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/vcd_resolve.sv @@
module vcd_resolve (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  vcd_pkg::match_t  data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [1:0]       status_o,
  output vcd_pkg::result_t result_o
);

  logic             valid_q;
  logic [1:0]       status_d, status_q;
  vcd_pkg::result_t res_d, res_q;

  logic [1:0]       ac_status;
  vcd_pkg::result_t ac_res;
  logic [27:0]      win;
  logic [5:0]       avail;
  logic [4:0]       sign_pos;
  logic [7:0]       esc_n;
  logic [7:0]       esc_ext;

  assign win      = data_i.base.win;
  assign avail    = data_i.base.avail;
  assign sign_pos = 5'd27 - data_i.code.len;
  assign esc_n    = win[15:8];
  assign esc_ext  = win[7:0];

  // AC coefficient path: table code, escape, or no match
  always_comb begin
    ac_status = vcd_pkg::ST_NOMATCH;
    ac_res    = '0;
    if (data_i.code.hit) begin
      if (avail < 6'(data_i.code.len) + 6'd1) begin
        ac_status = vcd_pkg::ST_MORE;
      end else begin
        ac_status       = vcd_pkg::ST_OK;
        ac_res.run      = {1'b0, data_i.code.run};
        ac_res.level    = win[sign_pos] ? 12'sd0 - $signed(12'(data_i.code.level))
                                        : $signed(12'(data_i.code.level));
        ac_res.consumed = data_i.code.len + 5'd1;
      end
    end else if (data_i.esc) begin
      ac_res.run = win[21:16];
      if (avail < vcd_pkg::ESC_HDR) begin
        ac_status = vcd_pkg::ST_MORE;
      end else if (data_i.base.mpeg1) begin
        if (avail < vcd_pkg::ESC1_SHORT) begin
          ac_status = vcd_pkg::ST_MORE;
        end else if (esc_n == vcd_pkg::ESC1_EXT_POS || esc_n == vcd_pkg::ESC1_EXT_NEG) begin
          if (avail < vcd_pkg::ESC1_LONG) begin
            ac_status = vcd_pkg::ST_MORE;
          end else begin
            ac_status       = vcd_pkg::ST_OK;
            ac_res.level    = (esc_n == vcd_pkg::ESC1_EXT_POS) ? $signed({4'h0, esc_ext})
                                                             : $signed({4'hF, esc_ext});
            ac_res.consumed = 5'(vcd_pkg::ESC1_LONG);
          end
        end else begin
          ac_status       = vcd_pkg::ST_OK;
          ac_res.level    = $signed({{4{esc_n[7]}}, esc_n});
          ac_res.consumed = 5'(vcd_pkg::ESC1_SHORT);
        end
      end else begin
        if (avail < vcd_pkg::ESC2_LEN) begin
          ac_status = vcd_pkg::ST_MORE;
        end else begin
          ac_status       = vcd_pkg::ST_OK;
          ac_res.level    = $signed(win[15:4]);
          ac_res.consumed = 5'(vcd_pkg::ESC2_LEN);
        end
      end
    end else if (avail < (win[27] ? 6'd2 : 6'd12)) begin
      ac_status = vcd_pkg::ST_MORE;
    end
    if (ac_status != vcd_pkg::ST_OK) begin
      ac_res = '0;
    end
  end

  // Command select; drop all fields unless decoded
  always_comb begin
    status_d = vcd_pkg::ST_NOMATCH;
    res_d    = '0;
    unique case (data_i.base.cmd)
      vcd_pkg::CMD_AC: begin
        status_d = ac_status;
        res_d    = ac_res;
      end
      vcd_pkg::CMD_FIRST: begin
        if (avail < 6'd1) begin
          status_d = vcd_pkg::ST_MORE;
        end else if (win[27]) begin
          if (avail < 6'd2) begin
            status_d = vcd_pkg::ST_MORE;
          end else begin
            status_d       = vcd_pkg::ST_OK;
            res_d.level    = win[26] ? -12'sd1 : 12'sd1;
            res_d.consumed = 5'd2;
          end
        end else begin
          status_d = ac_status;
          res_d    = ac_res;
        end
      end
      vcd_pkg::CMD_EOB: begin
        if (avail < 6'd2) begin
          status_d = vcd_pkg::ST_MORE;
        end else begin
          status_d  = vcd_pkg::ST_OK;
          res_d.eob = (win[27:26] == 2'b10);
        end
      end
      vcd_pkg::CMD_RSVD: begin
        status_d = vcd_pkg::ST_NOMATCH;
      end
      default: begin
        status_d = vcd_pkg::ST_NOMATCH;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign result_o = res_q;

endmodule
